@@ design/scta_pkg.sv @@
// Package for the size-class tile allocator.
// Holds shared types, codes, defaults and atlas geometry functions; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package scta_pkg;

    localparam int unsigned ATLAS_ORDER_DEF = 8;
    localparam int unsigned NUM_CLASSES_DEF = 7;
    localparam int unsigned CLS_W           = 3;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_TOO_LARGE    = 2'd1,
        ST_FREE_IGNORED = 2'd2
    } t_status;

    typedef struct packed {
        logic             kind;
        logic [7:0]       glyph_width;
        logic [7:0]       glyph_height;
        logic [7:0]       owner_face;
        logic [7:0]       owner_char;
        logic [CLS_W-1:0] free_class;
        logic [15:0]      free_tile;
    } t_request;

    typedef struct packed {
        t_status          status;
        logic [CLS_W-1:0] size_class;
        logic [15:0]      tile_number;
        logic [7:0]       tile_x;
        logic [7:0]       tile_y;
        logic             evicted;
        logic [7:0]       evicted_face;
        logic [7:0]       evicted_char;
    } t_result;

    function automatic int unsigned cls_shift(int unsigned c, int unsigned ao);
        return (c <= ao) ? (ao - c) : 0;
    endfunction

    function automatic int unsigned cls_tiles(int unsigned c, int unsigned ao,
                                              int unsigned nc);
        return (c < nc) ? (32'd1 << (2 * cls_shift(c, ao))) : 0;
    endfunction

    function automatic int unsigned class_base(int unsigned c, int unsigned ao,
                                               int unsigned nc);
        int unsigned acc;
        acc = 0;
        for (int unsigned i = 0; i < 8; i++) begin
            if (i < c) begin
                acc = acc + cls_tiles(i, ao, nc);
            end
        end
        return acc;
    endfunction

    function automatic int unsigned total_tiles(int unsigned ao, int unsigned nc);
        return class_base(8, ao, nc);
    endfunction

    // Smallest c with 2^c >= s; zero and one give class 0.
    function automatic logic [3:0] ceil_log2(logic [7:0] s);
        logic [3:0] res;
        res = 4'd8;
        for (int i = 7; i >= 0; i--) begin
            if ((9'd1 << i) >= {1'b0, s}) begin
                res = 4'(i);
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

@@ design/scta_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module scta_ram #(
    parameter int unsigned WIDTH = 17,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ design/scta_core.sv @@
// Allocation sequencer: per-class list heads and counts, and the read-modify-write
// steps on the link and owner memories. Depends on scta_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scta_core #(
    parameter int unsigned ATLAS_ORDER = scta_pkg::ATLAS_ORDER_DEF,
    parameter int unsigned NUM_CLASSES = scta_pkg::NUM_CLASSES_DEF,
    localparam int unsigned TW    = 2 * ATLAS_ORDER,
    localparam int unsigned PW    = TW + 1,
    localparam int unsigned TOTAL = scta_pkg::total_tiles(ATLAS_ORDER, NUM_CLASSES),
    localparam int unsigned AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_req_valid,
    output logic                    o_req_ready,
    input  wire scta_pkg::t_request i_req,
    output logic                    o_res_valid,
    input  wire logic               i_res_ready,
    output scta_pkg::t_result       o_res,
    output logic [AW-1:0]           o_raddr,
    output logic                    o_nx_we,
    output logic [AW-1:0]           o_nx_waddr,
    output logic [PW-1:0]           o_nx_wdata,
    input  wire logic [PW-1:0]      i_nx_rdata,
    output logic                    o_pv_we,
    output logic [AW-1:0]           o_pv_waddr,
    output logic [PW-1:0]           o_pv_wdata,
    input  wire logic [PW-1:0]      i_pv_rdata,
    output logic                    o_ow_we,
    output logic [AW-1:0]           o_ow_waddr,
    output logic [16:0]             o_ow_wdata,
    input  wire logic [16:0]        i_ow_rdata
);

    localparam int unsigned CIW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam logic [PW-1:0] NIL = {PW{1'b1}};

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DEC  = 7'b0000010,
        S_RD   = 7'b0000100,
        S_FREE = 7'b0001000,
        S_APP1 = 7'b0010000,
        S_APP2 = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state                      r_state, n_state;
    scta_pkg::t_request          r_req;
    logic [scta_pkg::CLS_W-1:0]  r_c, n_c;
    logic [TW-1:0]               r_t, n_t, r_ptail, n_ptail;
    logic                        r_evict, n_evict, r_pop, n_pop;
    scta_pkg::t_status           r_status, n_status;
    logic                        r_evd, n_evd;
    logic [7:0]                  r_ef, n_ef, r_ec, n_ec;
    logic [PW-1:0]               r_fresh [NUM_CLASSES];
    logic [PW-1:0]               r_fhead [NUM_CLASSES];
    logic [PW-1:0]               r_uhead [NUM_CLASSES];
    logic [PW-1:0]               r_utail [NUM_CLASSES];
    logic [PW-1:0]               n_fresh [NUM_CLASSES];
    logic [PW-1:0]               n_fhead [NUM_CLASSES];
    logic [PW-1:0]               n_uhead [NUM_CLASSES];
    logic [PW-1:0]               n_utail [NUM_CLASSES];

    logic [3:0]                  s_cl;
    logic [7:0]                  s_side;
    logic [CIW-1:0]              s_idx, r_idx;
    logic                        s_own_ok;
    logic [31:0]                 s_sh, s_loc, s_col, s_row;

    function automatic logic [AW-1:0] addr_of(logic [scta_pkg::CLS_W-1:0] c,
                                              logic [31:0] x);
        return AW'(scta_pkg::class_base(32'(c), ATLAS_ORDER, NUM_CLASSES) + x);
    endfunction

    assign o_req_ready = (r_state == S_IDLE);
    assign r_idx       = r_c[CIW-1:0];
    assign s_side      = (r_req.glyph_width > r_req.glyph_height) ?
                         r_req.glyph_width : r_req.glyph_height;
    assign s_cl        = scta_pkg::ceil_log2(s_side);
    assign s_own_ok    = i_ow_rdata[16] && (32'(r_t) < 32'(r_fresh[r_idx]));

    always_comb begin
        n_state  = r_state;
        n_c      = r_c;
        n_t      = r_t;
        n_ptail  = r_ptail;
        n_evict  = r_evict;
        n_pop    = r_pop;
        n_status = r_status;
        n_evd    = r_evd;
        n_ef     = r_ef;
        n_ec     = r_ec;
        n_fresh  = r_fresh;
        n_fhead  = r_fhead;
        n_uhead  = r_uhead;
        n_utail  = r_utail;
        s_idx    = '0;
        o_raddr    = '0;
        o_nx_we    = 1'b0;
        o_nx_waddr = '0;
        o_nx_wdata = '0;
        o_pv_we    = 1'b0;
        o_pv_waddr = '0;
        o_pv_wdata = '0;
        o_ow_we    = 1'b0;
        o_ow_waddr = '0;
        o_ow_wdata = '0;
        o_res_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_status = scta_pkg::ST_OK;
                n_evd    = 1'b0;
                n_ef     = '0;
                n_ec     = '0;
                n_evict  = 1'b0;
                n_pop    = 1'b0;
                if (r_req.kind == scta_pkg::KIND_ALLOC) begin
                    if (32'(s_cl) >= NUM_CLASSES) begin
                        n_status = scta_pkg::ST_TOO_LARGE;
                        n_state  = S_DONE;
                    end else begin
                        n_c   = s_cl[scta_pkg::CLS_W-1:0];
                        s_idx = s_cl[CIW-1:0];
                        if (r_fhead[s_idx] != NIL) begin
                            n_t     = r_fhead[s_idx][TW-1:0];
                            n_pop   = 1'b1;
                            n_state = S_RD;
                        end else if (32'(r_fresh[s_idx]) <
                                     scta_pkg::cls_tiles(32'(s_cl), ATLAS_ORDER,
                                                         NUM_CLASSES)) begin
                            n_t            = r_fresh[s_idx][TW-1:0];
                            n_fresh[s_idx] = r_fresh[s_idx] + PW'(1);
                            n_state        = S_APP1;
                        end else begin
                            n_t     = r_uhead[s_idx][TW-1:0];
                            n_evict = 1'b1;
                            n_state = S_RD;
                        end
                        o_raddr = addr_of(n_c, 32'(n_t));
                    end
                end else begin
                    if ((32'(r_req.free_class) >= NUM_CLASSES) ||
                        (32'(r_req.free_tile) >=
                         scta_pkg::cls_tiles(32'(r_req.free_class), ATLAS_ORDER,
                                             NUM_CLASSES))) begin
                        n_status = scta_pkg::ST_FREE_IGNORED;
                        n_state  = S_DONE;
                    end else begin
                        n_c     = r_req.free_class;
                        n_t     = TW'(r_req.free_tile);
                        o_raddr = addr_of(n_c, 32'(n_t));
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                if (r_pop) begin
                    n_fhead[r_idx] = i_nx_rdata;
                    n_state        = S_APP1;
                end else if (r_evict || s_own_ok) begin
                    if (r_evict) begin
                        n_evd   = s_own_ok;
                        n_ef    = s_own_ok ? i_ow_rdata[15:8] : 8'd0;
                        n_ec    = s_own_ok ? i_ow_rdata[7:0] : 8'd0;
                        n_state = S_APP1;
                    end else begin
                        n_state = S_FREE;
                    end
                    if (i_pv_rdata == NIL) begin
                        n_uhead[r_idx] = i_nx_rdata;
                    end else begin
                        o_nx_we    = 1'b1;
                        o_nx_waddr = addr_of(r_c, 32'(i_pv_rdata));
                        o_nx_wdata = i_nx_rdata;
                    end
                    if (i_nx_rdata == NIL) begin
                        n_utail[r_idx] = i_pv_rdata;
                    end else begin
                        o_pv_we    = 1'b1;
                        o_pv_waddr = addr_of(r_c, 32'(i_nx_rdata));
                        o_pv_wdata = i_pv_rdata;
                    end
                end else begin
                    n_status = scta_pkg::ST_FREE_IGNORED;
                    n_state  = S_DONE;
                end
            end
            S_FREE: begin
                o_nx_we        = 1'b1;
                o_nx_waddr     = addr_of(r_c, 32'(r_t));
                o_nx_wdata     = r_fhead[r_idx];
                n_fhead[r_idx] = PW'(r_t);
                o_ow_we        = 1'b1;
                o_ow_waddr     = addr_of(r_c, 32'(r_t));
                o_ow_wdata     = '0;
                n_state        = S_DONE;
            end
            S_APP1: begin
                o_nx_we    = 1'b1;
                o_nx_waddr = addr_of(r_c, 32'(r_t));
                o_nx_wdata = NIL;
                o_pv_we    = 1'b1;
                o_pv_waddr = addr_of(r_c, 32'(r_t));
                o_pv_wdata = r_utail[r_idx];
                o_ow_we    = 1'b1;
                o_ow_waddr = addr_of(r_c, 32'(r_t));
                o_ow_wdata = {1'b1, r_req.owner_face, r_req.owner_char};
                if (r_utail[r_idx] == NIL) begin
                    n_uhead[r_idx] = PW'(r_t);
                    n_state        = S_DONE;
                end else begin
                    n_ptail = r_utail[r_idx][TW-1:0];
                    n_state = S_APP2;
                end
                n_utail[r_idx] = PW'(r_t);
            end
            S_APP2: begin
                o_nx_we    = 1'b1;
                o_nx_waddr = addr_of(r_c, 32'(r_ptail));
                o_nx_wdata = PW'(r_t);
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_sh  = scta_pkg::cls_shift(32'(r_c), ATLAS_ORDER);
        s_loc = 32'(r_t) & ((32'd1 << (2 * s_sh)) - 32'd1);
        s_col = s_loc & ((32'd1 << s_sh) - 32'd1);
        s_row = s_loc >> s_sh;
        o_res = '0;
        o_res.status = r_status;
        if (r_status == scta_pkg::ST_OK) begin
            o_res.size_class   = r_c;
            o_res.tile_number  = 16'(32'(r_t));
            o_res.tile_x       = 8'(s_col << r_c);
            o_res.tile_y       = 8'(s_row << r_c);
            o_res.evicted      = r_evd;
            o_res.evicted_face = r_ef;
            o_res.evicted_char = r_ec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_fresh[i] <= '0;
                r_fhead[i] <= NIL;
                r_uhead[i] <= NIL;
                r_utail[i] <= NIL;
            end
        end else begin
            r_state <= n_state;
            r_fresh <= n_fresh;
            r_fhead <= n_fhead;
            r_uhead <= n_uhead;
            r_utail <= n_utail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req_valid) begin
            r_req <= i_req;
        end
        r_c      <= n_c;
        r_t      <= n_t;
        r_ptail  <= n_ptail;
        r_evict  <= n_evict;
        r_pop    <= n_pop;
        r_status <= n_status;
        r_evd    <= n_evd;
        r_ef     <= n_ef;
        r_ec     <= n_ec;
    end

endmodule
`default_nettype wire

@@ design/size_class_tile_allocator_fifo_evict_unit.sv @@
// Top level of the size-class tile allocator: link and owner memories,
// sequencer and output register. Depends on scta_pkg, scta_ram and scta_core.
//
// One request stream in, one result stream out, one result per transaction.
// A request (tuser = kind) either allocates a square tile for a glyph or frees
// a tile. Allocation takes a recently freed tile of the glyph's class first,
// then an untouched tile in raster order, and otherwise evicts the oldest used
// tile of the class and reports its owner. Oversize glyphs get status 1; frees
// of unowned or out-of-range tiles get status 2 and change nothing.
// One request is worked on at a time, and the steps of each are set by the
// dependent reads and writes through the single write port of each memory.
// s_tready is high only while the sequencer waits.
// The result sits in an output register; a stalled receiver holds the block in
// its last step, and a new request is taken once the result is registered.
// Synchronous reset empties all lists and counts; no memory clearing pass is
// needed, since tiles above each class's fill count read as unowned.
`timescale 1ns / 1ps
`default_nettype none
module size_class_tile_allocator_fifo_evict_unit #(
    parameter int unsigned ATLAS_ORDER = scta_pkg::ATLAS_ORDER_DEF,
    parameter int unsigned NUM_CLASSES = scta_pkg::NUM_CLASSES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // glyph_width, glyph_height, owner_face, owner_char, free_class, free_tile
    input  wire logic [55:0] i_s_tdata,
    // kind
    input  wire logic        i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // size_class, tile_number, tile_x, tile_y, evicted, evicted_face, evicted_char
    output logic [55:0]      o_m_tdata,
    // status
    output logic [1:0]       o_m_tuser
);

    localparam int unsigned TW    = 2 * ATLAS_ORDER;
    localparam int unsigned PW    = TW + 1;
    localparam int unsigned TOTAL = scta_pkg::total_tiles(ATLAS_ORDER, NUM_CLASSES);
    localparam int unsigned AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;

    scta_pkg::t_request req;
    scta_pkg::t_result  res, r_res;
    logic               res_valid, res_ready, r_ovalid;
    logic [AW-1:0]      raddr, nx_waddr, pv_waddr, ow_waddr;
    logic               nx_we, pv_we, ow_we;
    logic [PW-1:0]      nx_wdata, nx_rdata, pv_wdata, pv_rdata;
    logic [16:0]        ow_wdata, ow_rdata;

    always_comb begin
        req.kind         = i_s_tuser;
        req.glyph_width  = i_s_tdata[7:0];
        req.glyph_height = i_s_tdata[15:8];
        req.owner_face   = i_s_tdata[23:16];
        req.owner_char   = i_s_tdata[31:24];
        req.free_class   = i_s_tdata[34:32];
        req.free_tile    = i_s_tdata[50:35];
    end

    assign res_ready = !r_ovalid || i_m_tready;

    scta_core #(
        .ATLAS_ORDER(ATLAS_ORDER),
        .NUM_CLASSES(NUM_CLASSES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_s_tvalid),
        .o_req_ready(o_s_tready),
        .i_req      (req),
        .o_res_valid(res_valid),
        .i_res_ready(res_ready),
        .o_res      (res),
        .o_raddr    (raddr),
        .o_nx_we    (nx_we),
        .o_nx_waddr (nx_waddr),
        .o_nx_wdata (nx_wdata),
        .i_nx_rdata (nx_rdata),
        .o_pv_we    (pv_we),
        .o_pv_waddr (pv_waddr),
        .o_pv_wdata (pv_wdata),
        .i_pv_rdata (pv_rdata),
        .o_ow_we    (ow_we),
        .o_ow_waddr (ow_waddr),
        .o_ow_wdata (ow_wdata),
        .i_ow_rdata (ow_rdata)
    );

    scta_ram #(.WIDTH(PW), .DEPTH(TOTAL)) u_next_ram (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_waddr), .i_wdata(nx_wdata),
        .i_raddr(raddr), .o_rdata(nx_rdata)
    );

    scta_ram #(.WIDTH(PW), .DEPTH(TOTAL)) u_prev_ram (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_waddr), .i_wdata(pv_wdata),
        .i_raddr(raddr), .o_rdata(pv_rdata)
    );

    scta_ram #(.WIDTH(17), .DEPTH(TOTAL)) u_owner_ram (
        .i_clk(i_clk), .i_we(ow_we), .i_waddr(ow_waddr), .i_wdata(ow_wdata),
        .i_raddr(raddr), .o_rdata(ow_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_valid) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_res <= res;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_res.status;
    assign o_m_tdata  = {4'd0, r_res.evicted_char, r_res.evicted_face, r_res.evicted,
                         r_res.tile_y, r_res.tile_x, r_res.tile_number,
                         r_res.size_class};

endmodule
`default_nettype wire

@@ design/scta_checker.sv @@
// Port-level checker for the size-class tile allocator, bound to the top level.
// Depends on scta_pkg and size_class_tile_allocator_fifo_evict_unit.
`timescale 1ns / 1ps
`default_nettype none
module scta_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic [55:0] i_s_tdata,
    input wire logic        i_s_tuser,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [55:0] o_m_tdata,
    input wire logic [1:0]  o_m_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second transaction taken while busy");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == scta_pkg::ST_TOO_LARGE ||
                       o_m_tuser == scta_pkg::ST_FREE_IGNORED) |-> o_m_tdata == '0)
        else $error("rejected transaction carries data");

    a_evict_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[35] |-> o_m_tdata[51:36] == '0)
        else $error("owner reported without eviction");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser != 2'd3)
        else $error("undefined status code");

endmodule

bind size_class_tile_allocator_fifo_evict_unit scta_checker u_scta_checker (.*);
`default_nettype wire

@@ tb/size_class_tile_allocator_fifo_evict_unit_test.sv @@
// Self-checking testbench for size_class_tile_allocator_fifo_evict_unit.
// Holds a tile allocator predictor in a small scoreboard class and drives
// directed and random requests with random stalls. Depends on scta_pkg.
`timescale 1ns / 1ps
module size_class_tile_allocator_fifo_evict_unit_test;

    localparam int unsigned NCLS   = scta_pkg::NUM_CLASSES_DEF;
    localparam int unsigned AORD   = scta_pkg::ATLAS_ORDER_DEF;
    localparam int unsigned TILES  = 87380;
    localparam int unsigned NONE   = 32'hFFFF_FFFF;
    localparam int unsigned OWNED  = 32'h1_0000;
    localparam int          N_RAND = 780;

    class tile_scoreboard;
        int unsigned       fresh_cnt[8];
        int unsigned       freed_top[8];
        int unsigned       lru_head[8];
        int unsigned       lru_tail[8];
        int unsigned       base[8];
        int unsigned       nxt[TILES];
        int unsigned       prv[TILES];
        int unsigned       owner[TILES];
        scta_pkg::t_result pending[$];
        int                errors;
        int                n_requests;
        int                n_results;
        int                n_evictions;
        int                n_frees;

        function new();
            int unsigned acc;
            acc = 0;
            for (int c = 0; c < 8; c++) begin
                base[c] = acc;
                acc += tiles_of(c);
                fresh_cnt[c] = 0;
                freed_top[c] = NONE;
                lru_head[c] = NONE;
                lru_tail[c] = NONE;
            end
            foreach (owner[i]) owner[i] = 0;
        endfunction

        function int unsigned tiles_of(int unsigned c);
            int unsigned sh;
            sh = (c <= AORD) ? AORD - c : 0;
            return (c < NCLS) ? (32'd1 << (2 * sh)) : 0;
        endfunction

        function void place(ref scta_pkg::t_result r, input int unsigned c,
                            input int unsigned t);
            int unsigned sh;
            int unsigned loc;
            sh = (c <= AORD) ? AORD - c : 0;
            loc = t & ((32'd1 << (2 * sh)) - 1);
            r.size_class = c[2:0];
            r.tile_number = t[15:0];
            r.tile_x = 8'(((loc & ((32'd1 << sh) - 1)) << c) & 8'hFF);
            r.tile_y = 8'(((loc >> sh) << c) & 8'hFF);
        endfunction

        function void lru_append(int unsigned c, int unsigned t);
            nxt[base[c] + t] = NONE;
            prv[base[c] + t] = lru_tail[c];
            if (lru_tail[c] == NONE) lru_head[c] = t;
            else nxt[base[c] + lru_tail[c]] = t;
            lru_tail[c] = t;
        endfunction

        function void lru_unlink(int unsigned c, int unsigned t);
            int unsigned p;
            int unsigned n;
            p = prv[base[c] + t];
            n = nxt[base[c] + t];
            if (p == NONE) lru_head[c] = n;
            else nxt[base[c] + p] = n;
            if (n == NONE) lru_tail[c] = p;
            else prv[base[c] + n] = p;
        endfunction

        function void note_request(logic kind, logic [55:0] d);
            scta_pkg::t_result r;
            int unsigned       s;
            int unsigned       c;
            int unsigned       t;
            int unsigned       old;
            r = '0;
            n_requests++;
            if (kind == scta_pkg::KIND_ALLOC) begin
                s = (d[7:0] > d[15:8]) ? d[7:0] : d[15:8];
                c = 0;
                while ((32'd1 << c) < s) c++;
                if (c >= NCLS) begin
                    r.status = scta_pkg::ST_TOO_LARGE;
                end else begin
                    if (freed_top[c] != NONE) begin
                        t = freed_top[c];
                        freed_top[c] = nxt[base[c] + t];
                    end else if (fresh_cnt[c] < tiles_of(c)) begin
                        t = fresh_cnt[c];
                        fresh_cnt[c]++;
                    end else begin
                        t = lru_head[c];
                        lru_unlink(c, t);
                        old = owner[base[c] + t];
                        if (old & OWNED) begin
                            r.evicted = 1'b1;
                            r.evicted_face = old[15:8];
                            r.evicted_char = old[7:0];
                            n_evictions++;
                        end
                    end
                    lru_append(c, t);
                    owner[base[c] + t] = OWNED | {d[23:16], d[31:24]};
                    r.status = scta_pkg::ST_OK;
                    place(r, c, t);
                end
            end else begin
                c = d[34:32];
                t = d[50:35];
                if (c >= NCLS || t >= tiles_of(c) || !(owner[base[c] + t] & OWNED)) begin
                    r.status = scta_pkg::ST_FREE_IGNORED;
                end else begin
                    lru_unlink(c, t);
                    nxt[base[c] + t] = freed_top[c];
                    freed_top[c] = t;
                    owner[base[c] + t] = 0;
                    r.status = scta_pkg::ST_OK;
                    place(r, c, t);
                    n_frees++;
                end
            end
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(logic [1:0] status, logic [55:0] d);
            scta_pkg::t_result e;
            scta_pkg::t_result a;
            a.status = scta_pkg::t_status'(status);
            a.size_class = d[2:0];
            a.tile_number = d[18:3];
            a.tile_x = d[26:19];
            a.tile_y = d[34:27];
            a.evicted = d[35];
            a.evicted_face = d[43:36];
            a.evicted_char = d[51:44];
            n_results++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", a);
                return;
            end
            e = pending[0];
            pending.delete(0);
            if (a !== e || d[55:52] !== 4'd0) begin
                errors++;
                if (errors <= 10) $display("mismatch at result %0d: expected %p, got %p",
                                           n_results, e, a);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [55:0] i_s_tdata = '0;
    logic        i_s_tuser = 1'b0;
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [55:0] o_m_tdata;
    logic [1:0]  o_m_tuser;

    tile_scoreboard sb = new();
    bit quiet = 1'b0;
    bit hold_off_done = 1'b0;

    size_class_tile_allocator_fifo_evict_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) sb.note_request(i_s_tuser, i_s_tdata);
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tuser, o_m_tdata);
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!hold_off_done && sb.n_requests >= 300) begin
                hold_off_done = 1'b1;
                i_m_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else if (quiet || $urandom_range(0, 3) != 0) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(posedge i_clk);
            end
        end
    end

    task automatic send(logic kind, logic [7:0] w, logic [7:0] h, logic [7:0] face,
                        logic [7:0] chr, logic [2:0] fcls, logic [15:0] ftile);
        i_s_tvalid <= 1'b1;
        i_s_tuser <= kind;
        i_s_tdata <= {5'd0, ftile, fcls, chr, face, h, w};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic alloc(logic [7:0] w, logic [7:0] h);
        send(scta_pkg::KIND_ALLOC, w, h, 8'($urandom), 8'($urandom), 3'($urandom),
             16'($urandom));
    endtask

    task automatic release_tile(logic [2:0] c, logic [15:0] t);
        send(scta_pkg::KIND_FREE, 8'($urandom), 8'($urandom), 8'($urandom),
             8'($urandom), c, t);
    endtask

    task automatic random_request();
        int unsigned pick;
        int unsigned c;
        pick = $urandom_range(0, 99);
        c = $urandom_range(4, 6);
        if (pick < 45) begin
            alloc(8'($urandom_range(1 << (c - 1), 1 << c)), 8'($urandom_range(0, 16)));
        end else if (pick < 55) begin
            alloc(8'($urandom), 8'($urandom));
        end else if (pick < 60) begin
            alloc(8'($urandom_range(0, 8)), 8'($urandom_range(0, 8)));
        end else if (pick < 90) begin
            release_tile(3'(c), 16'($urandom_range(0, sb.tiles_of(c) - 1)));
        end else begin
            release_tile(3'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        send(scta_pkg::KIND_ALLOC, 8'd0, 8'd0, 8'hFF, 8'h00, 3'd7, 16'hFFFF);
        send(scta_pkg::KIND_ALLOC, 8'd1, 8'd1, 8'h00, 8'hFF, 3'd0, 16'h0000);
        send(scta_pkg::KIND_ALLOC, 8'd255, 8'd255, 8'hA5, 8'h5A, 3'd0, 16'd0);
        send(scta_pkg::KIND_ALLOC, 8'd65, 8'd1, 8'h01, 8'h02, 3'd0, 16'd0);
        send(scta_pkg::KIND_ALLOC, 8'd3, 8'd128, 8'h03, 8'h04, 3'd0, 16'd0);
        release_tile(3'd7, 16'd0);
        release_tile(3'd6, 16'd16);
        release_tile(3'd0, 16'd5000);
        release_tile(3'd0, 16'hFFFF);
        for (int i = 0; i < 17; i++) alloc(8'd64, 8'($urandom_range(0, 64)));
        release_tile(3'd6, 16'd3);
        release_tile(3'd6, 16'd3);
        alloc(8'd33, 8'd40);
        release_tile(3'd0, 16'd1);
        for (int i = 0; i < N_RAND; i++) begin
            if (i == N_RAND - 100) quiet = 1'b1;
            random_request();
        end
        i_s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Ran %0d requests and checked %0d results: %0d evictions, %0d frees.",
                 sb.n_requests, sb.n_results, sb.n_evictions, sb.n_frees);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("size_class_tile_allocator_fifo_evict_unit_test: clean");
        end else begin
            $display("Mismatch count: %0d", sb.errors);
            $display("size_class_tile_allocator_fifo_evict_unit_test: errors");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("Timed out with %0d results outstanding.", sb.pending.size());
        $display("size_class_tile_allocator_fifo_evict_unit_test: errors");
        $finish;
    end
endmodule
